// ===== design/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared widths, constants and types for the binary to decimal ASCII block.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 6;
    localparam int DIGIT_W   = 4;
    localparam int PLACE_W   = 4;
    localparam int WEIGHT_W  = 34;   // holds nine times the top place weight
    localparam int IN_DEPTH  = 2;
    localparam int OUT_DEPTH = 2;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [PLACE_W-1:0] UNITS_PLACE = 4'd9;

    // One result item as it sits in the result queue.
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last_digit;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    // Decimal weight of a place, most significant place first.
    function automatic logic [WEIGHT_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
        logic [WEIGHT_W-1:0] w;
        case (place)
            4'd0:    w = 34'd1000000000;
            4'd1:    w = 34'd100000000;
            4'd2:    w = 34'd10000000;
            4'd3:    w = 34'd1000000;
            4'd4:    w = 34'd100000;
            4'd5:    w = 34'd10000;
            4'd6:    w = 34'd1000;
            4'd7:    w = 34'd100;
            4'd8:    w = 34'd10;
            default: w = 34'd1;
        endcase
        return w;
    endfunction

endpackage

// ===== design/b2da_fifo.sv =====
// ----------------------------------------------------------------------------
// b2da_fifo
// Small first-in first-out queue; DEPTH must be a power of two, at least 2.
// ----------------------------------------------------------------------------
module b2da_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/b2da_digit.sv =====
// ----------------------------------------------------------------------------
// b2da_digit
// Digit engine: walks the ten decimal places of one value, one a cycle unless a digit waits on a full result queue.
// ----------------------------------------------------------------------------
module b2da_digit
    import b2da_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_val_avail,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_val_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output t_result            o_result
);

    logic                r_busy;
    logic [VALUE_W-1:0]  r_rest, n_rest;
    logic [PLACE_W-1:0]  r_place;
    logic                r_started;

    logic [WEIGHT_W-1:0] weight;
    logic [WEIGHT_W-1:0] sub;
    logic [DIGIT_W-1:0]  digit;
    logic                emit;
    logic                step;
    logic                done;
    logic                load;

    // Pick the largest multiple of the place weight that fits in the rest.
    always_comb begin
        weight = place_weight(r_place);
        digit  = '0;
        sub    = '0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, r_rest} >= weight * WEIGHT_W'(k)) begin
                digit = DIGIT_W'(k);
                sub   = weight * WEIGHT_W'(k);
            end
        end
        n_rest = r_rest - sub[VALUE_W-1:0];
    end

    assign emit = r_busy && (digit != '0 || r_started || r_place == UNITS_PLACE);
    assign step = r_busy && (!emit || !i_res_full);
    assign done = step && (r_place == UNITS_PLACE);
    assign load = i_val_avail && (!r_busy || done);

    assign o_val_pop           = load;
    assign o_res_push          = emit && !i_res_full;
    assign o_result.digit_char = ASCII_ZERO + CHAR_W'(digit);
    assign o_result.last_digit = (r_place == UNITS_PLACE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_place   <= '0;
            r_started <= 1'b0;
        end else if (load) begin
            r_busy    <= 1'b1;
            r_place   <= '0;
            r_started <= 1'b0;
        end else if (done) begin
            r_busy    <= 1'b0;
        end else if (step) begin
            r_place   <= r_place + 1'b1;
            r_started <= r_started || (digit != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rest <= i_value;
        end else if (step) begin
            r_rest <= n_rest;
        end
    end

endmodule

// ===== design/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned 32-bit binary to decimal ASCII digits, leading zeros suppressed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_value and raise push while full is low; the item
//   is taken at that edge. Values land in a small input queue.
//   Result channel: while empty is low, o_digit_char holds the ASCII code of
//   the oldest waiting digit and o_last_digit marks the units digit, the
//   final character of a run. Raise pop to take it.
//   Each value gives 1 to 10 characters, most significant first; zero gives
//   a single '0'.
// Timing:
//   The digit engine steps through a value one decimal place at a time and
//   loads the next value in the cycle its units digit leaves, so a steady
//   stream keeps it busy between values. The first character passes the
//   input queue, engine and result queue, plus one step per suppressed zero.
//   When the receiver stalls, the result queue fills, the engine holds on
//   the pending digit, then the input queue fills and full rises.
//   Synchronous reset empties both queues and idles the engine.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int P_IN_DEPTH  = IN_DEPTH,
    parameter int P_OUT_DEPTH = OUT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VALUE_W-1:0] i_value,
    output logic               empty,
    input  logic               pop,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic               o_last_digit
);

    logic [VALUE_W-1:0]  val_data;
    logic                val_empty;
    logic                val_pop;
    logic                res_full;
    logic                res_push;
    t_result             res_in;
    t_result             res_out;

    // Front: hold accepted values until the engine is free.
    b2da_fifo #(
        .WIDTH (VALUE_W),
        .DEPTH (P_IN_DEPTH)
    ) u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_value),
        .o_full  (full),
        .i_pop   (val_pop),
        .o_data  (val_data),
        .o_empty (val_empty)
    );

    // Engine: produce digits one place a cycle unless a digit waits on a full result queue.
    b2da_digit u_digit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_val_avail (!val_empty),
        .i_value     (val_data),
        .o_val_pop   (val_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (res_in)
    );

    // Result queue decouples the engine from a stalling receiver.
    b2da_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (P_OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_digit_char = res_out.digit_char;
    assign o_last_digit = res_out.last_digit;

endmodule
